// File: hdl/hvn_pkg.sv
// Shared types and constants of the heightmap vertex normal block.
// No dependencies; used by the top level and by the normalizer.
package hvn_pkg;

  localparam int unsigned MAX_GRID_DEF = 64;
  localparam logic [6:0]  GRID_RESET   = 7'd64;

  // Widths of the raw normal sum before normalizing
  localparam int XW = 19;   // signed X and Z sums
  localparam int AW_ABS = 18; // magnitude of X and Z
  localparam int YW = 11;   // Y sum, at most four steps of 256
  localparam int SW = 38;   // sum of squares
  localparam int LW = 31;   // root of the scaled sum of squares
  localparam int QW = 15;   // quotient bits of one component
  localparam logic [QW-1:0] UNIT_Q14 = 15'd16384;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_NORM,
    S_OUT
  } hvn_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_SQRT,
    N_DIV,
    N_DONE
  } norm_state_e;

endpackage

// File: hdl/hvn_norm.sv
// Normalizer: squares, bit-serial square root and bit-serial division.
// Depends on hvn_pkg.
module hvn_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [hvn_pkg::XW-1:0] x_i,
  input  logic        [hvn_pkg::YW-1:0] y_i,
  input  logic signed [hvn_pkg::XW-1:0] z_i,
  output logic                          done_o,
  output logic signed [15:0]            nx_o,
  output logic signed [15:0]            ny_o,
  output logic signed [15:0]            nz_o
);
  import hvn_pkg::*;

  norm_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [1:0]  comp_q, comp_d;

  logic [2:0]        neg_q;
  logic [AW_ABS-1:0] mag_q [3];
  logic [AW_ABS-1:0] mul_op;
  logic [2*AW_ABS-1:0] prod_q;
  logic [SW-1:0]     s_q;
  logic [SW+23:0]    rad_q;
  logic [32:0]       srem_q;
  logic [LW-1:0]     root_q;
  logic [34:0]       srem_sh, trial;
  logic [LW+AW_ABS-3:0] num_wide;
  logic [45:0]       num;
  logic [QW-1:0]     low_q;
  logic [32:0]       drem_q, drem_sh, dvsr;
  logic [QW-1:0]     quo_q, quo_sat;
  logic signed [15:0] res_q [3];
  logic signed [15:0] res_val;

  // Sequence the phases
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    done_o  = 1'b0;
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          state_d = N_SQ;
          cnt_d   = '0;
        end
      end
      N_SQ: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          state_d = N_SQRT;
          cnt_d   = '0;
        end
      end
      N_SQRT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(LW)) begin
          state_d = N_DIV;
          cnt_d   = '0;
          comp_d  = '0;
        end
      end
      N_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(QW + 1)) begin
          cnt_d = '0;
          if (comp_q == 2'd2) state_d = N_DONE;
          else comp_d = comp_q + 2'd1;
        end
      end
      N_DONE: begin
        done_o  = 1'b1;
        state_d = N_IDLE;
      end
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
    end
  end

  // One shared squarer
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    mul_op = mag_q[0];
      2'd1:    mul_op = mag_q[1];
      default: mul_op = mag_q[2];
    endcase
  end

  // Square root, two radicand bits a cycle
  assign srem_sh = {srem_q, rad_q[SW+23:SW+22]};
  assign trial   = {2'b00, root_q, 2'b01};

  // Division: one quotient bit a cycle, divisor 2L
  assign num_wide = {mag_q[comp_q], 27'd0};
  assign num      = 46'(num_wide) + 46'(root_q);
  assign dvsr     = {1'b0, root_q, 1'b0};
  assign drem_sh  = {drem_q[31:0], low_q[QW-1]};
  assign quo_sat  = (quo_q > UNIT_Q14) ? UNIT_Q14 : quo_q;
  assign res_val  = neg_q[comp_q] ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});

  always_ff @(posedge clk_i) begin
    if (state_q == N_IDLE && start_i) begin
      neg_q    <= {z_i[XW-1], 1'b0, x_i[XW-1]};
      mag_q[0] <= x_i[XW-1] ? AW_ABS'(-x_i) : AW_ABS'(x_i);
      mag_q[1] <= AW_ABS'(y_i);
      mag_q[2] <= z_i[XW-1] ? AW_ABS'(-z_i) : AW_ABS'(z_i);
      s_q      <= '0;
    end
    if (state_q == N_SQ) begin
      prod_q <= mul_op * mul_op;
      if (cnt_q != 6'd0) s_q <= s_q + SW'(prod_q);
      if (cnt_q == 6'd3) begin
        rad_q  <= {s_q + SW'(prod_q), 24'd0};
        srem_q <= '0;
        root_q <= '0;
      end
    end
    if (state_q == N_SQRT && cnt_q != 6'(LW)) begin
      rad_q <= {rad_q[SW+21:0], 2'b00};
      if (srem_sh >= trial) begin
        srem_q <= 33'(srem_sh - trial);
        root_q <= {root_q[LW-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh[32:0];
        root_q <= {root_q[LW-2:0], 1'b0};
      end
    end
    if (state_q == N_DIV) begin
      if (cnt_q == 6'd0) begin
        drem_q <= {2'b00, num[45:QW]};
        low_q  <= num[QW-1:0];
        quo_q  <= '0;
      end else if (cnt_q <= 6'(QW)) begin
        low_q <= {low_q[QW-2:0], 1'b0};
        if (drem_sh >= dvsr) begin
          drem_q <= drem_sh - dvsr;
          quo_q  <= {quo_q[QW-2:0], 1'b1};
        end else begin
          drem_q <= drem_sh;
          quo_q  <= {quo_q[QW-2:0], 1'b0};
        end
      end else begin
        res_q[comp_q] <= res_val;
      end
    end
  end

  assign nx_o = res_q[0];
  assign ny_o = res_q[1];
  assign nz_o = res_q[2];

endmodule

// File: hdl/heightmap_vertex_normals.sv
// Heightmap vertex normals: line buffers, sequencer and output register.
// Depends on hvn_pkg and hvn_norm.
//
// Heights arrive in raster order; each sample yields zero to three normals in raster
// order, the last marked by run_last_o. Each normal goes through reads from the row
// store, forming the sums, the shared squarer, the bit-serial square root, the
// bit-serial divider for each of the three components and the hand-over to the output
// register before out_valid_o. One sample is handled at a time; a low out_ready_i
// holds the result and delays the next. Samples of row 0 yield nothing and leave
// in_ready_o high. in_ready_o rises again once the last normal of a sample is taken.
// Writing the grid size (cfg_we_i) restarts the grid at vertex (0,0). No clearing
// pass after reset.
module heightmap_vertex_normals #(
  parameter int unsigned MAX_GRID = hvn_pkg::MAX_GRID_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         vertex_row_o,
  output logic [5:0]         vertex_col_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               run_last_o
);
  import hvn_pkg::*;

  localparam int CW    = $clog2(MAX_GRID);
  localparam int GW    = CW + 1;
  localparam int DEPTH = 3 * MAX_GRID;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] addr_of(input logic [1:0] slot, input logic [CW-1:0] col);
    addr_of = AW'(32'(slot) * MAX_GRID + 32'(col));
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    slot_inc = (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    slot_dec = (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  hvn_state_e state_q, state_d;
  logic [6:0]    grid_q;
  logic [GW-1:0] g_eff;
  logic [CW-1:0] row_q, col_q;
  logic [1:0]    slot_q;
  logic [CW-1:0] sr_q, sc_q;
  logic [1:0]    sslot_q;
  logic [2:0]    en_q, rest_en;
  logic [1:0]    job_q;
  logic [2:0]    rd_cnt_q;
  logic          accept, last_row;
  logic [CW-1:0] ti, tj;
  logic [1:0]    tslot;
  logic          has_up, has_dn, has_lf, has_rt;
  logic [AW-1:0] raddr;
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_q;
  logic signed [15:0] hs_q [5];
  logic signed [16:0] du, dd, dl, dr;
  logic signed [XW-1:0] sx, sz;
  logic [YW-1:0] sy;
  logic          norm_start, norm_done;
  logic signed [15:0] nx, ny, nz;
  logic [5:0]    vrow_q, vcol_q;
  logic signed [15:0] ox_q, oy_q, oz_q;
  logic          last_q;

  // Clamp grid size to the supported range
  always_comb begin
    if (grid_q < 7'd2) g_eff = GW'(2);
    else if (32'(grid_q) > MAX_GRID) g_eff = GW'(MAX_GRID);
    else g_eff = GW'(grid_q);
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_row   = (GW'(row_q) == g_eff - GW'(1));

  // Jobs still pending after the current one
  always_comb begin
    case (job_q)
      2'd0:    rest_en = en_q & 3'b110;
      2'd1:    rest_en = en_q & 3'b100;
      default: rest_en = 3'b000;
    endcase
  end

  // Target vertex of the current job
  always_comb begin
    case (job_q)
      2'd0: begin
        ti = sr_q - CW'(1); tj = sc_q; tslot = slot_dec(sslot_q);
      end
      2'd1: begin
        ti = sr_q; tj = sc_q - CW'(1); tslot = sslot_q;
      end
      default: begin
        ti = sr_q; tj = sc_q; tslot = sslot_q;
      end
    endcase
  end

  assign has_up = (ti != '0);
  assign has_dn = (GW'(ti) + GW'(1) < g_eff);
  assign has_lf = (tj != '0);
  assign has_rt = (GW'(tj) + GW'(1) < g_eff);

  // Neighbor address; absent neighbors reread the center
  always_comb begin
    raddr = addr_of(tslot, tj);
    case (rd_cnt_q)
      3'd1: if (has_up) raddr = addr_of(slot_dec(tslot), tj);
      3'd2: if (has_dn) raddr = addr_of(slot_inc(tslot), tj);
      3'd3: if (has_lf) raddr = addr_of(tslot, tj - CW'(1));
      3'd4: if (has_rt) raddr = addr_of(tslot, tj + CW'(1));
      default: raddr = addr_of(tslot, tj);
    endcase
  end

  // Row store
  always_ff @(posedge clk_i) begin
    if (accept) mem[addr_of(slot_q, col_q)] <= height_i;
    rd_q <= mem[raddr];
  end

  // Sum the cross products of existing neighbor pairs
  always_comb begin
    du = has_up ? 17'(hs_q[1]) - 17'(hs_q[0]) : '0;
    dd = has_dn ? 17'(hs_q[2]) - 17'(hs_q[0]) : '0;
    dl = has_lf ? 17'(hs_q[3]) - 17'(hs_q[0]) : '0;
    dr = has_rt ? 17'(hs_q[4]) - 17'(hs_q[0]) : '0;
    sx = '0;
    sy = '0;
    sz = '0;
    if (has_up && has_rt) begin
      sx = sx + XW'(du); sy = sy + YW'(256); sz = sz - XW'(dr);
    end
    if (has_rt && has_dn) begin
      sx = sx - XW'(dd); sy = sy + YW'(256); sz = sz - XW'(dr);
    end
    if (has_dn && has_lf) begin
      sx = sx - XW'(dd); sy = sy + YW'(256); sz = sz + XW'(dl);
    end
    if (has_lf && has_up) begin
      sx = sx + XW'(du); sy = sy + YW'(256); sz = sz + XW'(dl);
    end
  end

  assign norm_start = (state_q == S_SUM);

  hvn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .x_i     (sx),
    .y_i     (sy),
    .z_i     (sz),
    .done_o  (norm_done),
    .nx_o    (nx),
    .ny_o    (ny),
    .nz_o    (nz)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (row_q != '0 || last_row)) state_d = S_READ;
      end
      S_READ: if (rd_cnt_q == 3'd5) state_d = S_SUM;
      S_SUM:  state_d = S_NORM;
      S_NORM: if (norm_done) state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) state_d = (rest_en != 3'b000) ? S_READ : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      grid_q   <= GRID_RESET;
      row_q    <= '0;
      col_q    <= '0;
      slot_q   <= '0;
      en_q     <= '0;
      job_q    <= '0;
      rd_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        grid_q <= cfg_data_i;
        row_q  <= '0;
        col_q  <= '0;
        slot_q <= '0;
      end else if (accept) begin
        // advance the raster position
        if (GW'(col_q) + GW'(1) >= g_eff) begin
          col_q <= '0;
          if (last_row) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + CW'(1);
            slot_q <= slot_inc(slot_q);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (accept) begin
        en_q[0] <= (row_q != '0);
        en_q[1] <= last_row && (col_q != '0);
        en_q[2] <= last_row && (GW'(col_q) == g_eff - GW'(1));
        if (row_q != '0) job_q <= 2'd0;
        else if (col_q != '0) job_q <= 2'd1;
        else job_q <= 2'd2;
        rd_cnt_q <= '0;
      end
      if (state_q == S_READ) rd_cnt_q <= rd_cnt_q + 3'd1;
      if (state_q == S_OUT && out_ready_i) begin
        job_q    <= rest_en[1] ? 2'd1 : 2'd2;
        rd_cnt_q <= '0;
      end
    end
  end

  // Sample position, gathered heights and output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sr_q    <= row_q;
      sc_q    <= col_q;
      sslot_q <= slot_q;
    end
    if (state_q == S_READ && rd_cnt_q != 3'd0) hs_q[rd_cnt_q - 3'd1] <= rd_q;
    if (state_q == S_NORM && norm_done) begin
      vrow_q <= 6'(ti);
      vcol_q <= 6'(tj);
      ox_q   <= nx;
      oy_q   <= ny;
      oz_q   <= nz;
      last_q <= (rest_en == 3'b000);
    end
  end

  assign out_valid_o  = (state_q == S_OUT);
  assign vertex_row_o = vrow_q;
  assign vertex_col_o = vcol_q;
  assign normal_x_o   = ox_q;
  assign normal_y_o   = oy_q;
  assign normal_z_o   = oz_q;
  assign run_last_o   = last_q;

endmodule

// File: hdl/hvn_checker.sv
// Port-level checks of the heightmap vertex normal block, bound to the top level.
// Depends on heightmap_vertex_normals.
module hvn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        run_last_o,
  input logic [15:0] normal_y_o
);

  // Hold a stalled result valid with its normal_y unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_y_o))
    else $error("stalled result changed");

  // Normals always point upward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !normal_y_o[15] && normal_y_o != 16'd0)
    else $error("normal does not point up");

  // No new sample while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // More results follow a transaction that is not the last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> !in_ready_o)
    else $error("run ended early");

  // A result never appears right after a sample is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result without computation");

endmodule

bind heightmap_vertex_normals hvn_checker u_hvn_checker (.*);

// File: tb/heightmap_vertex_normals_check.sv
// Checker for the heightmap vertex normal block: watches the config port and
// both channels, predicts every normal and compares it field by field.
// Depends on hvn_pkg.
`timescale 1ns / 100ps

module heightmap_vertex_normals_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] height_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [5:0]         vertex_row_i,
  input  logic [5:0]         vertex_col_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic               run_last_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import hvn_pkg::*;

  typedef struct packed {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        last;
  } normal_t;

  localparam int GMAX = MAX_GRID_DEF;

  normal_t            normal_q[$];
  logic signed [15:0] line_buf [3][GMAX];
  logic [6:0]         grid_reg;
  int                 row_pos;
  int                 col_pos;

  assign pending_o = normal_q.size();

  function automatic int grid_eff(logic [6:0] g);
    if (g < 2) return 2;
    if (g > GMAX) return GMAX;
    return int'(g);
  endfunction

  function automatic longint height_at(int r, int c);
    return longint'(line_buf[r % 3][c]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Round half away from zero, clamp to one in Q1.14
  function automatic logic [15:0] to_q14(longint v, longint unsigned len);
    longint unsigned a;
    longint unsigned q;
    a = longint'(v < 0 ? -v : v);
    q = ((a << 27) + len) / (2 * len);
    if (q > 16384) q = 16384;
    return v < 0 ? 16'(-longint'(q)) : 16'(q);
  endfunction

  function automatic normal_t vertex_normal(int i, int j, int g);
    normal_t n;
    longint h0, du, dd, dl, dr, x, y, z;
    longint unsigned s, len;
    bit up, dn, lf, rt;
    h0 = height_at(i, j);
    up = i >= 1; dn = i + 1 < g; lf = j >= 1; rt = j + 1 < g;
    du = up ? height_at(i - 1, j) - h0 : 0;
    dd = dn ? height_at(i + 1, j) - h0 : 0;
    dl = lf ? height_at(i, j - 1) - h0 : 0;
    dr = rt ? height_at(i, j + 1) - h0 : 0;
    x = 0; y = 0; z = 0;
    if (up && rt) begin x += du; y += 256; z -= dr; end
    if (rt && dn) begin x -= dd; y += 256; z -= dr; end
    if (dn && lf) begin x -= dd; y += 256; z += dl; end
    if (lf && up) begin x += du; y += 256; z += dl; end
    s = x * x + y * y + z * z;
    len = int_sqrt(s << 24);
    if (len == 0) len = 1;
    n.row  = 6'(i);
    n.col  = 6'(j);
    n.nx   = to_q14(x, len);
    n.ny   = to_q14(y, len);
    n.nz   = to_q14(z, len);
    n.last = 1'b0;
    return n;
  endfunction

  // Store one sample and queue the normals it completes
  task automatic predict_sample(logic signed [15:0] h);
    int g, r, c, n0;
    g = grid_eff(grid_reg);
    r = row_pos;
    c = col_pos;
    n0 = normal_q.size();
    if (r >= g || c >= g) begin
      r = 0;
      c = 0;
    end
    line_buf[r % 3][c] = h;
    if (r >= 1) normal_q.push_back(vertex_normal(r - 1, c, g));
    if (r == g - 1) begin
      if (c >= 1) normal_q.push_back(vertex_normal(r, c - 1, g));
      if (c == g - 1) normal_q.push_back(vertex_normal(r, c, g));
    end
    if (normal_q.size() > n0) normal_q[normal_q.size() - 1].last = 1'b1;
    c++;
    if (c >= g) begin
      c = 0;
      r++;
      if (r >= g) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic check_normal();
    normal_t e;
    if (normal_q.size() == 0) begin
      $error("unexpected normal for vertex (%0d,%0d)", vertex_row_i, vertex_col_i);
      fail_count_o++;
      return;
    end
    e = normal_q.pop_front();
    if (vertex_row_i !== e.row) begin
      $error("vertex_row expected %0d actual %0d", e.row, vertex_row_i);
      fail_count_o++;
    end
    if (vertex_col_i !== e.col) begin
      $error("vertex_col expected %0d actual %0d", e.col, vertex_col_i);
      fail_count_o++;
    end
    if (normal_x_i !== e.nx) begin
      $error("normal_x expected %0d actual %0d", $signed(e.nx), normal_x_i);
      fail_count_o++;
    end
    if (normal_y_i !== e.ny) begin
      $error("normal_y expected %0d actual %0d", $signed(e.ny), normal_y_i);
      fail_count_o++;
    end
    if (normal_z_i !== e.nz) begin
      $error("normal_z expected %0d actual %0d", $signed(e.nz), normal_z_i);
      fail_count_o++;
    end
    if (run_last_i !== e.last) begin
      $error("run_last expected %0d actual %0d", e.last, run_last_i);
      fail_count_o++;
    end
  endtask

  // Track config, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_reg <= GRID_RESET;
      row_pos <= 0;
      col_pos <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        grid_reg = cfg_data_i;
        row_pos = 0;
        col_pos = 0;
      end
      if (in_valid_i && in_ready_i) predict_sample(height_i);
      if (out_valid_i && out_ready_i) check_normal();
    end
  end

endmodule

// File: tb/heightmap_vertex_normals_test.sv
// Testbench top for the heightmap vertex normal block: clock, reset, stimulus
// and verdict. Depends on hvn_pkg, the block and heightmap_vertex_normals_check.
`timescale 1ns / 100ps

module heightmap_vertex_normals_test;

  localparam int RANDOM_SAMPLES = 320;
  localparam int QUIET_CYCLES   = 400;
  localparam int CYCLE_LIMIT    = 1000000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [6:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] height;
  logic               out_valid;
  logic               out_ready;
  logic [5:0]         vertex_row;
  logic [5:0]         vertex_col;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               run_last;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  bit                 no_gaps;
  int                 grid_now;
  int                 sample_count;

  heightmap_vertex_normals dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .height_i     (height),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .vertex_row_o (vertex_row),
    .vertex_col_o (vertex_col),
    .normal_x_o   (normal_x),
    .normal_y_o   (normal_y),
    .normal_z_o   (normal_z),
    .run_last_o   (run_last)
  );

  heightmap_vertex_normals_check check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .height_i     (height),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .vertex_row_i (vertex_row),
    .vertex_col_i (vertex_col),
    .normal_x_i   (normal_x),
    .normal_y_i   (normal_y),
    .normal_z_i   (normal_z),
    .run_last_i   (run_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drive one sample, honoring a random gap before it
  task automatic send_height(logic signed [15:0] h);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    height <= h;
    do @(posedge clk_i); while (!in_ready);
    sample_count++;
  endtask

  // Hold off until every queued normal has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [6:0] g);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= g;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    grid_now = g < 2 ? 2 : (g > 64 ? 64 : int'(g));
  endtask

  function automatic logic signed [15:0] rand_height(bit smooth);
    if (smooth) return 16'(int'($urandom_range(0, 2047)) - 1024);
    return 16'($urandom);
  endfunction

  // Output side: random stalls, with stretches of none
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    int g, n, cut;
    bit smooth;
    logic [6:0] pick;
    cycles = 0;
    no_gaps = 1'b0;
    sample_count = 0;
    grid_now = 64;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    height = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: three samples of the first row at reset size, then the smallest grids and extremes
    send_height(16'sh7fff);
    send_height(-16'sh8000);
    send_height(16'sh0000);
    write_grid(7'd0);
    send_height(16'sh7fff);
    send_height(-16'sh8000);
    send_height(-16'sh8000);
    send_height(16'sh7fff);
    write_grid(7'd1);
    send_height(16'sh0000);
    send_height(16'sh0000);
    send_height(16'sh0000);
    send_height(16'sh0000);
    write_grid(7'd3);
    send_height(-16'sh8000);
    send_height(16'sh7fff);
    send_height(-16'sh8000);
    send_height(16'sh7fff);
    send_height(-16'sh0001);
    send_height(16'sh7fff);
    send_height(-16'sh8000);
    send_height(16'sh0100);
    send_height(-16'sh8000);

    // Random grids: mostly whole grids, some cut short, a few at the top size and only partly sent
    sample_count = 0;
    while (sample_count < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 7))
        0:       pick = 7'd2;
        1:       pick = 7'($urandom_range(65, 127));
        2:       pick = 7'd64;
        3:       pick = 7'($urandom_range(0, 1));
        default: pick = 7'($urandom_range(3, 9));
      endcase
      write_grid(pick);
      g = grid_now;
      no_gaps = ($urandom_range(0, 3) == 0);
      smooth = $urandom_range(0, 1);
      n = g > 16 ? 2 * g + $urandom_range(1, g) : g * g;
      cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n;
      for (int k = 0; k < cut && sample_count < RANDOM_SAMPLES; k++) begin
        send_height(rand_height(smooth));
        // Sometimes pause once mid-grid until the block has caught up
        if (k == cut / 2 && $urandom_range(0, 3) == 0) drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
